### design/shb_pkg.sv
// Package for the string hash bucket block: widths, step codes and the finish-step table.
package shb_pkg;

    localparam int unsigned W_BYTE      = 8;
    localparam int unsigned W_LEN       = 16;
    localparam int unsigned W_HASH      = 32;
    localparam int unsigned W_TABLE     = 31;
    localparam int unsigned W_PEND      = 24;
    localparam int unsigned W_IDX       = 4;
    localparam int unsigned W_AMT       = 5;
    localparam int unsigned DIV_STEPS   = 32;
    localparam int unsigned W_DIV_CNT   = $clog2(DIV_STEPS);
    localparam int unsigned DEF_MAX_MESSAGE_BYTES = 65535;
    localparam logic [W_TABLE-1:0] TABLE_SIZE_RESET = 31'd1024;

    // Operations of the shared finish unit.
    typedef enum logic [2:0] {
        OP_ADD_SHR = 3'd0,  // h += h >> amt
        OP_XOR_SHL = 3'd1,  // h ^= h << amt
        OP_ADD_LO  = 3'd2,  // h += low 16 bits of the pending bytes
        OP_ADD_SX0 = 3'd3,  // h += sign-extended first pending byte
        OP_XOR_SX2 = 3'd4   // h ^= sign-extended third pending byte << 18
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [W_AMT-1:0] amt;
        logic             fin;
    } t_step;

    function automatic logic [W_HASH-1:0] sext8(input logic [W_BYTE-1:0] b);
        return {{(W_HASH-W_BYTE){b[W_BYTE-1]}}, b};
    endfunction

    // The six avalanche steps that close every hash.
    function automatic t_step aval_step(input logic [W_IDX-1:0] idx);
        t_step s;
        s.fin = 1'b0;
        case (idx)
            4'd0: begin s.op = OP_XOR_SHL; s.amt = 5'd3;  end
            4'd1: begin s.op = OP_ADD_SHR; s.amt = 5'd5;  end
            4'd2: begin s.op = OP_XOR_SHL; s.amt = 5'd4;  end
            4'd3: begin s.op = OP_ADD_SHR; s.amt = 5'd17; end
            4'd4: begin s.op = OP_XOR_SHL; s.amt = 5'd25; end
            default: begin s.op = OP_ADD_SHR; s.amt = 5'd6; s.fin = 1'b1; end
        endcase
        return s;
    endfunction

    // Step number idx of the finish sequence for a tail of cnt bytes.
    function automatic t_step seq_step(input logic [1:0] cnt, input logic [W_IDX-1:0] idx);
        t_step            s;
        logic [W_IDX-1:0] tail_len;
        case (cnt)
            2'd0:    tail_len = 4'd0;
            2'd3:    tail_len = 4'd4;
            default: tail_len = 4'd3;
        endcase
        s = aval_step(idx - tail_len);
        if (idx < tail_len) begin
            s.fin = 1'b0;
            case (cnt)
                2'd3: begin
                    case (idx)
                        4'd0:    begin s.op = OP_ADD_LO;  s.amt = 5'd0;  end
                        4'd1:    begin s.op = OP_XOR_SHL; s.amt = 5'd16; end
                        4'd2:    begin s.op = OP_XOR_SX2; s.amt = 5'd0;  end
                        default: begin s.op = OP_ADD_SHR; s.amt = 5'd11; end
                    endcase
                end
                2'd2: begin
                    case (idx)
                        4'd0:    begin s.op = OP_ADD_LO;  s.amt = 5'd0;  end
                        4'd1:    begin s.op = OP_XOR_SHL; s.amt = 5'd11; end
                        default: begin s.op = OP_ADD_SHR; s.amt = 5'd17; end
                    endcase
                end
                default: begin
                    case (idx)
                        4'd0:    begin s.op = OP_ADD_SX0; s.amt = 5'd0;  end
                        4'd1:    begin s.op = OP_XOR_SHL; s.amt = 5'd10; end
                        default: begin s.op = OP_ADD_SHR; s.amt = 5'd1;  end
                    endcase
                end
            endcase
        end
        return s;
    endfunction

endpackage

### design/shb_ifs.sv
// Channel interfaces of the string hash bucket block: byte input, result output, configuration.
interface shb_in_if import shb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [W_BYTE-1:0] data_byte;
    logic [W_LEN-1:0]  message_length;
    logic              last;
    modport source (output valid, output data_byte, output message_length, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input message_length, input last,
                    output ready);
endinterface

interface shb_out_if import shb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [W_HASH-1:0]  hash_value;
    logic [W_TABLE-1:0] bucket;
    modport source (output valid, output hash_value, output bucket, input ready);
    modport sink   (input valid, input hash_value, input bucket, output ready);
endinterface

interface shb_cfg_if import shb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [W_TABLE-1:0] wdata;
    modport source (output valid, output wdata, input ready);
    modport sink   (input valid, input wdata, output ready);
endinterface

### design/string_hash_bucket_top.sv
// Top level of the string hash bucket block: byte mixer, finish sequencer and bucket divider.
// A word without last is absorbed and the block is ready again at once. A word with last
// runs 6 to 10 finish steps on the shared finish unit and then 32 divide steps before the
// result stands in the output register; the shared finish unit and the one-bit-per-cycle
// divider run in turn, and the block takes no byte while they run.
// Reset (i_rst_n, synchronous, active low) drops any partial string and any pending result
// and sets table_size to 1024.
module string_hash_bucket_top
    import shb_pkg::*;
#(
    parameter int unsigned MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    shb_in_if.sink      i_in,
    shb_out_if.source   o_out,
    shb_cfg_if.sink     i_cfg
);

    // The sequencer: bytes are taken in S_IDLE, the tail and avalanche run in S_FIN,
    // the bucket is found in S_DIV, and S_DONE waits for room in the output register.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FIN  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state               r_state;
    logic [W_TABLE-1:0]   r_table_size;
    logic [W_HASH-1:0]    r_hash;
    logic [W_PEND-1:0]    r_pend;
    logic [1:0]           r_phase;
    logic                 r_in_msg;
    logic [W_IDX-1:0]     r_idx;
    logic [W_HASH-1:0]    r_dvd;
    logic [W_TABLE-1:0]   r_rem;
    logic [W_DIV_CNT-1:0] r_cnt;
    logic                 r_out_valid;
    logic [W_HASH-1:0]    r_hash_out;
    logic [W_TABLE-1:0]   r_bucket_out;

    logic [W_HASH-1:0]    n_hash;
    logic [W_PEND-1:0]    n_pend;
    logic [1:0]           n_phase;
    logic [W_HASH-1:0]    n_step_hash;
    logic [W_TABLE-1:0]   n_rem;

    logic                 in_acc;
    logic                 out_free;
    t_step                step;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_hash_out;
    assign o_out.bucket     = r_bucket_out;

    // Byte mixer. The first word of a string seeds the hash with its saturated length
    // and starts an empty chunk. A fourth byte completes a little-endian chunk, which
    // is mixed into the running hash right away.
    always_comb begin
        logic [W_HASH-1:0] base_h;
        logic [W_PEND-1:0] base_p;
        logic [1:0]        base_ph;
        logic [W_HASH-1:0] chunk;
        logic [W_HASH-1:0] h1;
        logic [W_HASH-1:0] t1;
        logic [W_HASH-1:0] h2;
        if (r_in_msg) begin
            base_h  = r_hash;
            base_p  = r_pend;
            base_ph = r_phase;
        end else begin
            if (32'(i_in.message_length) > 32'(MAX_MESSAGE_BYTES)) begin
                base_h = 32'(MAX_MESSAGE_BYTES);
            end else begin
                base_h = 32'(i_in.message_length);
            end
            base_p  = '0;
            base_ph = 2'd0;
        end
        chunk = {i_in.data_byte, base_p};
        h1    = base_h + {16'd0, chunk[15:0]};
        t1    = {5'd0, chunk[31:16], 11'd0} ^ h1;
        h2    = {h1[15:0], 16'd0} ^ t1;
        n_hash  = base_h;
        n_pend  = base_p;
        n_phase = base_ph + 2'd1;
        case (base_ph)
            2'd0: n_pend[7:0]   = i_in.data_byte;
            2'd1: n_pend[15:8]  = i_in.data_byte;
            2'd2: n_pend[23:16] = i_in.data_byte;
            default: begin
                n_hash = h2 + (h2 >> 11);
                n_pend = '0;
            end
        endcase
    end

    // Shared finish unit: one tail or avalanche step per cycle, chosen by the table.
    assign step = seq_step(r_phase, r_idx);

    always_comb begin
        case (step.op)
            OP_ADD_SHR: n_step_hash = r_hash + (r_hash >> step.amt);
            OP_XOR_SHL: n_step_hash = r_hash ^ (r_hash << step.amt);
            OP_ADD_LO:  n_step_hash = r_hash + {16'd0, r_pend[15:0]};
            OP_ADD_SX0: n_step_hash = r_hash + sext8(r_pend[7:0]);
            OP_XOR_SX2: n_step_hash = r_hash ^ (sext8(r_pend[23:16]) << 18);
            default:    n_step_hash = r_hash;
        endcase
    end

    // Restoring divider: one quotient bit per cycle, only the remainder is kept.
    always_comb begin
        logic [W_HASH-1:0] trial;
        trial = {r_rem, r_dvd[W_HASH-1]};
        if (trial >= {1'b0, r_table_size}) begin
            n_rem = W_TABLE'(trial - {1'b0, r_table_size});
        end else begin
            n_rem = trial[W_TABLE-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_table_size <= TABLE_SIZE_RESET;
            r_in_msg     <= 1'b0;
            r_phase      <= 2'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_table_size <= i_cfg.wdata;
            end
            // In S_DONE the output register is reloaded below when it frees up.
            if (r_out_valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_hash  <= n_hash;
                        r_pend  <= n_pend;
                        r_phase <= n_phase;
                        r_idx   <= '0;
                        if (i_in.last) begin
                            // The string ends here; the next word starts a new one.
                            r_in_msg <= 1'b0;
                            r_state  <= S_FIN;
                        end else begin
                            r_in_msg <= 1'b1;
                        end
                    end
                end
                S_FIN: begin
                    r_hash <= n_step_hash;
                    r_idx  <= r_idx + 4'd1;
                    if (step.fin) begin
                        r_dvd   <= n_step_hash;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_dvd <= {r_dvd[W_HASH-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == W_DIV_CNT'(DIV_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_hash_out   <= r_hash;
                        r_bucket_out <= (r_table_size == '0) ? '0 : r_rem;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A last word always hands the string to the finish unit.
    a_last_starts_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.last) |=> (r_state == S_FIN))
        else $error("last word did not start the finish sequence");

    // The divider counts every cycle it runs.
    a_div_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt != W_DIV_CNT'(DIV_STEPS - 1))
        |=> (r_state == S_DIV && r_cnt == $past(r_cnt) + 1'b1))
        else $error("divider step count broke");

    // The finished remainder lies below a nonzero table size.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_table_size != '0) |-> (r_rem < r_table_size))
        else $error("bucket remainder not below table size");

    // A waiting result is never replaced before it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_hash_out)))
        else $error("pending result overwritten");

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for string_hash_bucket_top: streamed strings checked against a hash predictor.
module tb;
    import shb_pkg::*;

    // Longest stretch without any handshake before the run is declared hung. The slowest
    // correct stretch is a finish pass plus a long receiver stall and a long sender gap,
    // well under this figure.
    localparam int unsigned QUIET_LIMIT     = 2000;
    // Cycles let pass after the last result before a register write or the end of the run,
    // a little more than the latency of one full finish pass.
    localparam int unsigned SETTLE_CYCLES   = 50;
    localparam int unsigned BYTES_PER_PHASE = 86;
    localparam int unsigned NUM_SIZES       = 7;

    // One word of the byte channel and one word of the result channel.
    typedef struct packed {
        logic [W_BYTE-1:0] data_byte;
        logic [W_LEN-1:0]  message_length;
        logic              last;
    } byte_word_t;

    typedef struct packed {
        logic [W_HASH-1:0]  hash_value;
        logic [W_TABLE-1:0] bucket;
    } hash_word_t;

    // Content styles for generated strings. TXT_FIXED takes its bytes from a pattern.
    typedef enum int {
        TXT_RANDOM,
        TXT_PRINTABLE,
        TXT_HIGH,
        TXT_EXTREME,
        TXT_FIXED
    } text_style_e;

    // Receiver behaviors, each held for a random number of cycles.
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_TRICKLE,
        RX_BLOCKED
    } rx_mode_e;

    logic clk;
    logic rst_n;

    shb_in_if  in_ch ();
    shb_out_if out_ch ();
    shb_cfg_if cfg_ch ();

    string_hash_bucket_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Predictor state: the hash so far, the bytes of an unfinished chunk (earliest byte in
    // the low bits), how many of them are held, and whether a string is open.
    logic [W_HASH-1:0]  run_hash;
    logic [W_PEND-1:0]  run_pend;
    logic [1:0]         run_count;
    logic               run_open;
    logic [W_TABLE-1:0] cur_table_size;

    byte_word_t  string_byte_q [$];
    hash_word_t  predicted_hashes [$];
    int unsigned bytes_queued = 0;
    int unsigned bytes_taken  = 0;
    int unsigned errors       = 0;

    int unsigned gap_left     = 0;
    int unsigned burst_left   = 1;
    rx_mode_e    rx_mode      = RX_OPEN;
    int unsigned rx_left      = 0;
    int unsigned quiet_cycles = 0;

    always #5 clk = ~clk;

    // Mixes one full 4-byte little-endian chunk into the running hash.
    function automatic logic [W_HASH-1:0] mix_word(input logic [W_HASH-1:0] h_in,
                                                   input logic [W_HASH-1:0] chunk);
        logic [W_HASH-1:0] h;
        logic [W_HASH-1:0] t;
        h = h_in + {16'd0, chunk[15:0]};
        t = ({16'd0, chunk[31:16]} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    // Folds in the 1-, 2- or 3-byte tail and applies the six-step avalanche. Lone tail
    // bytes and the third byte of a 3-byte tail count as signed chars.
    function automatic logic [W_HASH-1:0] finish_hash(input logic [W_HASH-1:0] h_in,
                                                      input logic [W_PEND-1:0] pend,
                                                      input logic [1:0]        cnt);
        logic [W_HASH-1:0] h;
        h = h_in;
        case (cnt)
            2'd3: begin
                h += {16'd0, pend[15:0]};
                h ^= h << 16;
                h ^= {{24{pend[23]}}, pend[23:16]} << 18;
                h += h >> 11;
            end
            2'd2: begin
                h += {16'd0, pend[15:0]};
                h ^= h << 11;
                h += h >> 17;
            end
            2'd1: begin
                h += {{24{pend[7]}}, pend[7:0]};
                h ^= h << 10;
                h += h >> 1;
            end
            default: begin
            end
        endcase
        h ^= h << 3;
        h += h >> 5;
        h ^= h << 4;
        h += h >> 17;
        h ^= h << 25;
        h += h >> 6;
        return h;
    endfunction

    // Takes one accepted byte into the predictor and, on the last byte of a string, queues
    // the hash and bucket that the block must return.
    function automatic void absorb_byte(input logic [W_BYTE-1:0] b,
                                        input logic [W_LEN-1:0]  len,
                                        input logic              lst);
        logic [W_HASH-1:0] h;
        logic [W_HASH-1:0] rem;
        hash_word_t        r;
        if (!run_open) begin
            // The length is read only on the first byte, as the seed, saturated.
            run_hash  = ({16'd0, len} > DEF_MAX_MESSAGE_BYTES) ?
                        W_HASH'(DEF_MAX_MESSAGE_BYTES) : {16'd0, len};
            run_pend  = '0;
            run_count = 2'd0;
            run_open  = 1'b1;
        end
        if (run_count == 2'd3) begin
            run_hash  = mix_word(run_hash, {b, run_pend});
            run_pend  = '0;
            run_count = 2'd0;
        end else begin
            run_pend  = run_pend | ({16'd0, b} << (8 * run_count));
            run_count = run_count + 2'd1;
        end
        if (lst) begin
            h = finish_hash(run_hash, run_pend, run_count);
            r.hash_value = h;
            if (cur_table_size != '0) begin
                rem      = h % {1'b0, cur_table_size};
                r.bucket = rem[W_TABLE-1:0];
            end else begin
                // A table size of zero gives bucket zero.
                r.bucket = '0;
            end
            predicted_hashes.push_back(r);
            run_hash  = '0;
            run_pend  = '0;
            run_count = 2'd0;
            run_open  = 1'b0;
        end
    endfunction

    // The sender. A word stays on the channel until it is taken. Words go out in bursts of
    // random length, and each burst is followed by a gap of random length, from none at all
    // to longer than a whole finish pass, so that gaps land on every phase of the block.
    always @(posedge clk) begin : byte_driver
        byte_word_t nxt;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                absorb_byte(in_ch.data_byte, in_ch.message_length, in_ch.last);
                bytes_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (string_byte_q.size() != 0) begin
                    nxt = string_byte_q.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.data_byte      <= nxt.data_byte;
                    in_ch.message_length <= nxt.message_length;
                    in_ch.last           <= nxt.last;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 32);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left = 0;
                            4, 5, 6:    gap_left = $urandom_range(1, 3);
                            7, 8:       gap_left = $urandom_range(4, 16);
                            default:    gap_left = $urandom_range(17, 60);
                        endcase
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // The receiver. Each result word is compared field by field with the oldest
    // prediction. Ready follows its own pattern: open, coin flips, a trickle, or blocked.
    always @(posedge clk) begin : result_receiver
        hash_word_t want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (predicted_hashes.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected: expected none, actual hash %h bucket %0d",
                             $time, out_ch.hash_value, out_ch.bucket);
                end else begin
                    want = predicted_hashes.pop_front();
                    if (out_ch.hash_value !== want.hash_value) begin
                        errors++;
                        $display("%0t: hash_value mismatch: expected %h, actual %h",
                                 $time, want.hash_value, out_ch.hash_value);
                    end
                    if (out_ch.bucket !== want.bucket) begin
                        errors++;
                        $display("%0t: bucket mismatch: expected %0d, actual %0d",
                                 $time, want.bucket, out_ch.bucket);
                    end
                end
            end
            if (rx_left == 0) begin
                rx_mode = rx_mode_e'($urandom_range(0, 3));
                rx_left = $urandom_range(8, 80);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN:    out_ch.ready <= 1'b1;
                RX_COIN:    out_ch.ready <= ($urandom_range(0, 1) != 0);
                RX_TRICKLE: out_ch.ready <= ($urandom_range(0, 7) == 0);
                default:    out_ch.ready <= 1'b0;
            endcase
        end
    end

    // The watchdog ends a run in which no channel has moved a word for too long.
    always @(posedge clk) begin : watchdog
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL string_hash_bucket_top");
            $finish;
        end
    end

    // Queues one string of nbytes bytes. The seed length goes on the first byte; later
    // bytes carry random length fields, which the block must ignore.
    task automatic push_string(input int unsigned nbytes, input logic [W_LEN-1:0] seed_len,
                               input text_style_e style, input logic [63:0] pattern);
        byte_word_t w;
        for (int unsigned i = 0; i < nbytes; i++) begin
            case (style)
                TXT_RANDOM:    w.data_byte = W_BYTE'($urandom_range(0, 255));
                TXT_PRINTABLE: w.data_byte = W_BYTE'($urandom_range(32, 126));
                TXT_HIGH:      w.data_byte = W_BYTE'($urandom_range(128, 255));
                TXT_EXTREME:   w.data_byte = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                default:       w.data_byte = pattern[8 * (i % 8) +: 8];
            endcase
            w.message_length = (i == 0) ? seed_len : W_LEN'($urandom);
            w.last           = (i == nbytes - 1);
            string_byte_q.push_back(w);
        end
        bytes_queued += nbytes;
    endtask

    // Waits until every queued byte has been taken and every predicted result has come
    // back, then lets the block settle.
    task automatic wait_drained();
        while (bytes_taken != bytes_queued || predicted_hashes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes table_size through the configuration channel; the predictor takes the new
    // value at the edge where the word is accepted.
    task automatic write_table_size(input logic [W_TABLE-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.wdata <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cur_table_size = value;
        cfg_ch.valid <= 1'b0;
    endtask

    // A phase of random strings. Most are short with an honest length field; some are
    // longer, and some carry a length field that disagrees with the bytes sent. With
    // pause_midway set, the sender stops halfway until every result is back.
    task automatic run_random_phase(input int unsigned goal, input bit pause_midway);
        int unsigned start;
        int unsigned nb;
        logic [W_LEN-1:0] seed;
        bit paused;
        start  = bytes_queued;
        paused = 1'b0;
        while (bytes_queued - start < goal) begin
            if (pause_midway && !paused && (bytes_queued - start) >= goal / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            nb = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            case ($urandom_range(0, 19))
                16, 17:  seed = W_LEN'($urandom);
                18:      seed = '0;
                19:      seed = '1;
                default: seed = W_LEN'(nb);
            endcase
            push_string(nb, seed, text_style_e'($urandom_range(0, 3)), 64'd0);
        end
        wait_drained();
    endtask

    initial begin
        logic [W_TABLE-1:0] sizes [NUM_SIZES];

        clk   = 1'b0;
        rst_n = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.data_byte      = '0;
        in_ch.message_length = '0;
        in_ch.last           = 1'b0;
        out_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.wdata         = '0;
        run_hash       = '0;
        run_pend       = '0;
        run_count      = 2'd0;
        run_open       = 1'b0;
        cur_table_size = TABLE_SIZE_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed strings at the reset table size. They cover lone tail bytes of zero,
        // all ones and with the sign bit set, a 2-byte tail of all ones, 3-byte tails with
        // and without a sign-extended third byte, a full chunk with no tail, a chunk plus
        // a lone byte, and seeds of zero, the maximum and a wrong length.
        push_string(1, 16'd1,    TXT_FIXED, 64'h00);
        push_string(1, 16'hFFFF, TXT_FIXED, 64'hFF);
        push_string(1, 16'd0,    TXT_FIXED, 64'h80);
        push_string(2, 16'd2,    TXT_FIXED, 64'hFFFF);
        push_string(3, 16'd3,    TXT_FIXED, 64'h80_0201);
        push_string(3, 16'd3,    TXT_FIXED, 64'h7F_FFFF);
        push_string(4, 16'd4,    TXT_FIXED, 64'hFFFF_FFFF);
        push_string(5, 16'd9,    TXT_FIXED, 64'h80_7F01_FE00);
        wait_drained();

        // Random phases over a range of table sizes, the extremes among them, and zero.
        sizes[0] = 31'd1;
        sizes[1] = 31'd7;
        sizes[2] = 31'h7FFF_FFFF;
        sizes[3] = 31'd0;
        sizes[4] = W_TABLE'($urandom_range(1, 32'h7FFF_FFFF));
        sizes[5] = W_TABLE'($urandom_range(2, 5000));
        sizes[6] = TABLE_SIZE_RESET;
        for (int k = 0; k < NUM_SIZES; k++) begin
            write_table_size(sizes[k]);
            run_random_phase(BYTES_PER_PHASE, k == 1);
        end

        if (errors == 0) begin
            $display("PASS string_hash_bucket_top");
        end else begin
            $display("FAIL string_hash_bucket_top");
        end
        $finish;
    end

endmodule
